// ===== rtl/pwhm_pkg.sv =====
// pwhm_pkg: beat types, operation and status codes for the wildcard host matcher
// no dependencies
`timescale 1ns / 1ps

package pwhm_pkg;

    typedef struct packed {
        logic        [2:0]  operation;
        logic        [7:0]  char_byte;
        logic signed [31:0] priority_req;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] entry_index;
    } t_out_beat;

    localparam logic [2:0] OP_PAT    = 3'd0;
    localparam logic [2:0] OP_COMMIT = 3'd1;
    localparam logic [2:0] OP_HOST   = 3'd2;
    localparam logic [2:0] OP_END    = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_MATCH    = 3'd3;
    localparam logic [2:0] ST_NO_MATCH = 3'd4;

    localparam logic [7:0] STAR_CH  = 8'h2A;
    localparam logic [7:0] QMARK_CH = 8'h3F;

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/priority_wildcard_host_matcher.sv =====
// priority_wildcard_host_matcher: pattern table with ranked glob matching of hostnames
// depends on pwhm_pkg; pattern, reach, priority and rank rows live in local memories
`timescale 1ns / 1ps

// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_beat)
// output  | out       | o_out_valid / i_out_ready  | o_out_data (t_out_beat)
//
// pattern byte and commit are handled as they are accepted; hostname byte and hostname end
// sweep the entry rows, one entry row read and written back per cycle
// sort compares each entry against every row, one row read per compare
// synchronous active-low reset clears control; memories need no clearing pass
// a commit or hostname end waits while an earlier result beat is still unread

module priority_wildcard_host_matcher #(
    parameter int ENTRIES     = 8,
    parameter int PATTERN_LEN = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pwhm_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pwhm_pkg::t_out_beat o_out_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = $clog2(PATTERN_LEN + 1);
    localparam int L1 = PATTERN_LEN + 1;
    localparam int BW = PATTERN_LEN * 8;
    localparam int RW = LW + BW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HOST = 3'd1;
    localparam logic [2:0] S_END  = 3'd2;
    localparam logic [2:0] S_SA   = 3'd3;
    localparam logic [2:0] S_SB   = 3'd4;
    localparam logic [2:0] S_SJ   = 3'd5;
    localparam logic [2:0] S_COPY = 3'd6;

    function automatic logic [L1-1:0] f_star(input logic [BW-1:0] b, input logic [LW-1:0] len);
        logic [L1-1:0] s;
        s = '0;
        for (int k = 0; k < PATTERN_LEN; k++) begin
            s[k] = (LW'(k) < len) && (b[k*8 +: 8] == pwhm_pkg::STAR_CH);
        end
        return s;
    endfunction

    function automatic logic [L1-1:0] f_close(input logic [L1-1:0] r, input logic [L1-1:0] s);
        logic [L1-1:0] t;
        t = r & s;
        return r | ((s + t) ^ s ^ t);
    endfunction

    function automatic logic [L1-1:0] f_adv(input logic [L1-1:0] r, input logic [BW-1:0] b,
                                            input logic [LW-1:0] len, input logic [7:0] c);
        logic [L1-1:0] nr;
        logic [7:0]    p;
        nr = '0;
        for (int k = 0; k < PATTERN_LEN; k++) begin
            p = b[k*8 +: 8];
            if (r[k] && (LW'(k) < len)) begin
                if (p == pwhm_pkg::STAR_CH) begin
                    nr[k] = 1'b1;
                end else if (p == pwhm_pkg::QMARK_CH || p == c) begin
                    nr[k+1] = 1'b1;
                end
            end
        end
        return nr;
    endfunction

    // memories
    logic [RW-1:0]       r_pat_mem   [ENTRIES];
    logic [L1-1:0]       r_reach_mem [ENTRIES];
    logic signed [31:0]  r_prio_mem  [ENTRIES];
    logic [IW-1:0]       r_rank_mem  [ENTRIES];
    logic [IW-1:0]       r_nrank_mem [ENTRIES];
    logic [RW-1:0]       r_pat_q;
    logic [L1-1:0]       r_reach_q;
    logic signed [31:0]  r_prio_q;
    logic [IW-1:0]       r_rank_q;
    logic [IW-1:0]       r_nrank_q;

    // control
    logic [2:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic [LW-1:0]       r_blen;
    logic                r_ovf;
    logic                r_term;
    logic                r_hterm;
    logic [BW-1:0]       r_buf;
    logic [7:0]          r_ch;
    logic [CW-1:0]       r_addr;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic [IW-1:0]       r_e;
    logic signed [31:0]  r_pe;
    logic [IW-1:0]       r_re;
    logic [IW-1:0]       r_rk;
    logic                r_found;
    logic [IW-1:0]       r_best;
    logic [IW-1:0]       r_best_rank;
    logic                r_ovalid;
    pwhm_pkg::t_out_beat r_out;

    logic                w_acc;
    logic                w_sweep;
    logic                w_issue;
    logic                w_done;
    logic [IW-1:0]       w_raddr;
    logic [IW-1:0]       w_waddr;
    logic                w_commit_ok;
    logic                w_pbyte_wr;
    logic [BW-1:0]       w_bytes;
    logic [LW-1:0]       w_len;
    logic [L1-1:0]       w_star;
    logic [L1-1:0]       w_adv;
    logic [L1-1:0]       w_init;
    logic [L1-1:0]       w_new_init;
    logic                w_hit;
    logic                w_better;
    logic                w_reach_we;
    logic [L1-1:0]       w_reach_wd;
    logic                w_rank_we;
    logic [IW-1:0]       w_rank_wd;
    logic                w_nrank_we;
    logic [7:0]          w_lch;
    logic                w_res_op;
    logic                w_oset;

    assign w_res_op   = (i_in_data.operation == pwhm_pkg::OP_COMMIT) ||
                        (i_in_data.operation == pwhm_pkg::OP_END);
    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready || !w_res_op);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_lch      = pwhm_pkg::f_lower(i_in_data.char_byte);

    assign w_sweep = (r_state == S_HOST) || (r_state == S_END) ||
                     (r_state == S_SJ) || (r_state == S_COPY);
    assign w_issue = w_sweep && (r_addr < r_cnt);
    assign w_done  = w_sweep && !w_issue && !r_pv;
    assign w_raddr = (r_state == S_SA) ? r_e : r_addr[IW-1:0];
    assign w_waddr = (r_state == S_IDLE) ? r_cnt[IW-1:0] : r_pidx;

    // result beat loaded this cycle
    assign w_oset = (w_acc && (i_in_data.operation == pwhm_pkg::OP_COMMIT)) ||
                    (w_acc && (i_in_data.operation == pwhm_pkg::OP_END) && (r_cnt == '0)) ||
                    ((r_state == S_END) && w_done);

    assign w_commit_ok = w_acc && (i_in_data.operation == pwhm_pkg::OP_COMMIT) &&
                         (r_cnt < CW'(ENTRIES)) && !r_ovf;
    assign w_pbyte_wr  = w_acc && (i_in_data.operation == pwhm_pkg::OP_PAT) && !r_term &&
                         (i_in_data.char_byte != 8'h00) && (r_blen < LW'(PATTERN_LEN));

    // row datapath
    assign w_bytes    = r_pat_q[BW-1:0];
    assign w_len      = r_pat_q[BW +: LW];
    assign w_star     = f_star(w_bytes, w_len);
    assign w_adv      = f_close(f_adv(r_reach_q, w_bytes, w_len, r_ch), w_star);
    assign w_init     = f_close(L1'(1), w_star);
    assign w_new_init = f_close(L1'(1), f_star(r_buf, r_blen));
    assign w_hit      = r_reach_q[w_len];
    assign w_better   = w_hit && (!r_found || (r_rank_q < r_best_rank));

    assign w_reach_we = w_commit_ok || (r_pv && ((r_state == S_HOST) || (r_state == S_END)));
    assign w_reach_wd = w_commit_ok ? w_new_init : ((r_state == S_HOST) ? w_adv : w_init);
    assign w_rank_we  = w_commit_ok || (r_pv && (r_state == S_COPY));
    assign w_rank_wd  = w_commit_ok ? r_cnt[IW-1:0] : r_nrank_q;
    assign w_nrank_we = (r_state == S_SJ) && w_done;

    always_ff @(posedge i_clk) begin
        if (w_commit_ok) begin
            r_pat_mem[w_waddr]  <= {r_blen, r_buf};
            r_prio_mem[w_waddr] <= i_in_data.priority_req;
        end
        if (w_reach_we) begin
            r_reach_mem[w_waddr] <= w_reach_wd;
        end
        if (w_rank_we) begin
            r_rank_mem[w_waddr] <= w_rank_wd;
        end
        if (w_nrank_we) begin
            r_nrank_mem[r_e] <= r_rk;
        end
        r_pat_q   <= r_pat_mem[w_raddr];
        r_reach_q <= r_reach_mem[w_raddr];
        r_prio_q  <= r_prio_mem[w_raddr];
        r_rank_q  <= r_rank_mem[w_raddr];
        r_nrank_q <= r_nrank_mem[w_raddr];
    end

    // pattern build buffer
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PATTERN_LEN; k++) begin
            if (w_pbyte_wr && (r_blen == LW'(k))) begin
                r_buf[k*8 +: 8] <= w_lch;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr[IW-1:0];
        if (w_acc && i_in_data.operation == pwhm_pkg::OP_HOST) begin
            r_ch <= w_lch;
        end
        if (r_state == S_SB) begin
            r_pe <= r_prio_q;
            r_re <= r_rank_q;
        end
        if (r_state == S_SB) begin
            r_rk <= '0;
        end else if (r_state == S_SJ && r_pv &&
                     ((r_prio_q < r_pe) || ((r_prio_q == r_pe) && (r_rank_q < r_re)))) begin
            r_rk <= r_rk + 1'b1;
        end
        if (w_acc && i_in_data.operation == pwhm_pkg::OP_END) begin
            r_found <= 1'b0;
        end else if (r_state == S_END && r_pv && w_better) begin
            r_found     <= 1'b1;
            r_best      <= r_pidx;
            r_best_rank <= r_rank_q;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_blen   <= '0;
            r_ovf    <= 1'b0;
            r_term   <= 1'b0;
            r_hterm  <= 1'b0;
            r_addr   <= '0;
            r_pv     <= 1'b0;
            r_e      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pv <= w_issue;
            if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (w_oset) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (w_acc) begin
                        case (i_in_data.operation)
                            pwhm_pkg::OP_PAT: begin
                                if (!r_term) begin
                                    if (i_in_data.char_byte == 8'h00) begin
                                        r_term <= 1'b1;
                                    end else if (r_blen >= LW'(PATTERN_LEN)) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_blen <= r_blen + 1'b1;
                                    end
                                end
                            end
                            pwhm_pkg::OP_COMMIT: begin
                                r_blen   <= '0;
                                r_ovf    <= 1'b0;
                                r_term   <= 1'b0;
                                if (r_cnt >= CW'(ENTRIES)) begin
                                    r_out <= '{status: pwhm_pkg::ST_FULL, entry_index: 3'd0};
                                end else if (r_ovf) begin
                                    r_out <= '{status: pwhm_pkg::ST_TOO_LONG,
                                               entry_index: 3'd0};
                                end else begin
                                    r_out <= '{status: pwhm_pkg::ST_ADDED,
                                               entry_index: 3'(r_cnt)};
                                    r_cnt <= r_cnt + 1'b1;
                                end
                            end
                            pwhm_pkg::OP_HOST: begin
                                if (!r_hterm) begin
                                    if (i_in_data.char_byte == 8'h00) begin
                                        r_hterm <= 1'b1;
                                    end else if (r_cnt != '0) begin
                                        r_state <= S_HOST;
                                    end
                                end
                            end
                            pwhm_pkg::OP_END: begin
                                if (r_cnt == '0) begin
                                    r_hterm  <= 1'b0;
                                    r_out    <= '{status: pwhm_pkg::ST_NO_MATCH,
                                                  entry_index: 3'd0};
                                end else begin
                                    r_state <= S_END;
                                end
                            end
                            pwhm_pkg::OP_SORT: begin
                                if (r_cnt != '0) begin
                                    r_e     <= '0;
                                    r_state <= S_SA;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_HOST: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_END: begin
                    if (w_done) begin
                        r_state  <= S_IDLE;
                        r_hterm  <= 1'b0;
                        if (r_found) begin
                            r_out <= '{status: pwhm_pkg::ST_MATCH, entry_index: 3'(r_best)};
                        end else begin
                            r_out <= '{status: pwhm_pkg::ST_NO_MATCH, entry_index: 3'd0};
                        end
                    end
                end
                S_SA: begin
                    r_state <= S_SB;
                end
                S_SB: begin
                    r_addr  <= '0;
                    r_state <= S_SJ;
                end
                S_SJ: begin
                    if (w_done) begin
                        r_addr <= '0;
                        if (CW'(r_e) + 1'b1 == r_cnt) begin
                            r_state <= S_COPY;
                        end else begin
                            r_e     <= r_e + 1'b1;
                            r_state <= S_SA;
                        end
                    end
                end
                S_COPY: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ENTRIES))
        else $error("entry count above table size");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= r_cnt)
        else $error("sweep address past entry count");

    a_pv_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_HOST || r_state == S_END || r_state == S_SJ ||
                  r_state == S_COPY))
        else $error("row returned outside a sweep");

    a_commit_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.operation == pwhm_pkg::OP_COMMIT) |=> o_out_valid)
        else $error("commit gave no result beat");

endmodule

// ===== tb/priority_wildcard_host_matcher_tb.sv =====
// priority_wildcard_host_matcher_tb: self-checking bench for the wildcard host matcher
// depends on pwhm_pkg and priority_wildcard_host_matcher; predicts each result beat
`timescale 1ns / 1ps

module priority_wildcard_host_matcher_tb;

    localparam int ENTRIES     = 8;
    localparam int PATTERN_LEN = 63;
    localparam int CYCLE_LIMIT = 1000000;

    // operation codes with no function
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    pwhm_pkg::t_in_beat  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    pwhm_pkg::t_out_beat o_out_data;

    priority_wildcard_host_matcher #(
        .ENTRIES    (ENTRIES),
        .PATTERN_LEN(PATTERN_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // predictor state
    logic [7:0]         pat_mem [ENTRIES][PATTERN_LEN];
    int                 pat_len [ENTRIES];
    logic signed [31:0] prio    [ENTRIES];
    int                 rank    [ENTRIES];
    logic [63:0]        reach   [ENTRIES];
    logic [7:0]         build_buf [PATTERN_LEN];
    int                 n_entries;
    int                 build_len;
    bit                 build_ovf;
    bit                 build_done;
    bit                 host_done;

    pwhm_pkg::t_in_beat  pending_beats[$];
    pwhm_pkg::t_out_beat expected_results[$];
    int        n_errors;
    int        cycles;
    bit        stim_done;
    bit        long_stall;
    bit        send_hold;
    int        burst_left;
    int        gap_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] lc(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [63:0] closure(input int e, input logic [63:0] r);
        for (int k = 0; k < pat_len[e]; k++) begin
            if (r[k] && pat_mem[e][k] == pwhm_pkg::STAR_CH) begin
                r[k+1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] step_reach(input int e, input logic [63:0] r,
                                               input logic [7:0] c);
        logic [63:0] nr;
        nr = '0;
        for (int k = 0; k < pat_len[e]; k++) begin
            if (r[k]) begin
                if (pat_mem[e][k] == pwhm_pkg::STAR_CH) begin
                    nr[k] = 1'b1;
                end else if (pat_mem[e][k] == pwhm_pkg::QMARK_CH || pat_mem[e][k] == c) begin
                    nr[k+1] = 1'b1;
                end
            end
        end
        return closure(e, nr);
    endfunction

    task automatic queue_beat(input pwhm_pkg::t_in_beat b);
        pending_beats = {pending_beats, b};
    endtask

    task automatic expect_beat(input pwhm_pkg::t_out_beat b);
        expected_results = {expected_results, b};
    endtask

    task automatic predict_beat(input pwhm_pkg::t_in_beat b);
        pwhm_pkg::t_out_beat res;
        int        best;
        int        nr [ENTRIES];
        case (b.operation)
            pwhm_pkg::OP_PAT: begin
                if (!build_done) begin
                    if (b.char_byte == 8'h00) begin
                        build_done = 1'b1;
                    end else if (build_len >= PATTERN_LEN) begin
                        build_ovf = 1'b1;
                    end else begin
                        build_buf[build_len] = lc(b.char_byte);
                        build_len++;
                    end
                end
            end
            pwhm_pkg::OP_COMMIT: begin
                res.entry_index = '0;
                if (n_entries >= ENTRIES) begin
                    res.status = pwhm_pkg::ST_FULL;
                end else if (build_ovf) begin
                    res.status = pwhm_pkg::ST_TOO_LONG;
                end else begin
                    for (int k = 0; k < PATTERN_LEN; k++) begin
                        pat_mem[n_entries][k] = (k < build_len) ? build_buf[k] : 8'h00;
                    end
                    pat_len[n_entries] = build_len;
                    prio[n_entries]    = b.priority_req;
                    rank[n_entries]    = n_entries;
                    reach[n_entries]   = closure(n_entries, 64'd1);
                    res.status         = pwhm_pkg::ST_ADDED;
                    res.entry_index    = n_entries[2:0];
                    n_entries++;
                end
                build_len  = 0;
                build_ovf  = 1'b0;
                build_done = 1'b0;
                expect_beat(res);
            end
            pwhm_pkg::OP_HOST: begin
                if (!host_done) begin
                    if (b.char_byte == 8'h00) begin
                        host_done = 1'b1;
                    end else begin
                        for (int e = 0; e < n_entries; e++) begin
                            reach[e] = step_reach(e, reach[e], lc(b.char_byte));
                        end
                    end
                end
            end
            pwhm_pkg::OP_END: begin
                best = -1;
                for (int e = 0; e < n_entries; e++) begin
                    if (reach[e][pat_len[e]] && (best < 0 || rank[e] < rank[best])) begin
                        best = e;
                    end
                end
                res.status      = (best >= 0) ? pwhm_pkg::ST_MATCH : pwhm_pkg::ST_NO_MATCH;
                res.entry_index = (best >= 0) ? best[2:0] : 3'd0;
                for (int e = 0; e < n_entries; e++) begin
                    reach[e] = closure(e, 64'd1);
                end
                host_done = 1'b0;
                expect_beat(res);
            end
            pwhm_pkg::OP_SORT: begin
                for (int e = 0; e < n_entries; e++) begin
                    nr[e] = 0;
                    for (int j = 0; j < n_entries; j++) begin
                        if (prio[j] < prio[e] || (prio[j] == prio[e] && rank[j] < rank[e])) begin
                            nr[e]++;
                        end
                    end
                end
                for (int e = 0; e < n_entries; e++) begin
                    rank[e] = nr[e];
                end
            end
            default: ;
        endcase
    endtask

    function automatic pwhm_pkg::t_in_beat mk(input logic [2:0] op, input logic [7:0] c,
                                              input logic [31:0] p);
        pwhm_pkg::t_in_beat b;
        b.operation    = op;
        b.char_byte    = c;
        b.priority_req = p;
        return b;
    endfunction

    function automatic logic [7:0] rand_char();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return pwhm_pkg::STAR_CH;
            1: return pwhm_pkg::QMARK_CH;
            2: return 8'h41 + 8'($urandom_range(0, 3));
            3: return 8'h2E;
            4: return 8'($urandom_range(1, 255));
            default: return 8'h61 + 8'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [7:0] rand_host_char();
        case ($urandom_range(0, 5))
            0: return 8'h41 + 8'($urandom_range(0, 3));
            1: return 8'h2E;
            2: return 8'($urandom_range(1, 255));
            default: return 8'h61 + 8'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic add_pattern(input int len, input logic [31:0] p);
        for (int k = 0; k < len; k++) begin
            queue_beat(mk(pwhm_pkg::OP_PAT, rand_char(), $urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            queue_beat(mk(pwhm_pkg::OP_PAT, 8'h00, $urandom));
            queue_beat(mk(pwhm_pkg::OP_PAT, rand_char(), $urandom));
        end
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'($urandom), p));
    endtask

    task automatic add_host(input int len);
        for (int k = 0; k < len; k++) begin
            queue_beat(mk(pwhm_pkg::OP_HOST, rand_host_char(), $urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            queue_beat(mk(pwhm_pkg::OP_HOST, 8'h00, $urandom));
            queue_beat(mk(pwhm_pkg::OP_HOST, rand_host_char(), $urandom));
        end
        queue_beat(mk(pwhm_pkg::OP_END, 8'($urandom), $urandom));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() != 0 && !send_hold) begin
                i_in_data  <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_beat(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $realtime, o_out_data);
                    n_errors++;
                end else begin
                    pwhm_pkg::t_out_beat exp_b;
                    exp_b = expected_results.pop_front();
                    if (exp_b.status !== o_out_data.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 exp_b.status, o_out_data.status);
                        n_errors++;
                    end
                    if (exp_b.entry_index !== o_out_data.entry_index) begin
                        $display("%0t: entry_index expected %0d actual %0d", $realtime,
                                 exp_b.entry_index, o_out_data.entry_index);
                        n_errors++;
                    end
                end
            end
            if (long_stall) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    // long receiver hold-off
    initial begin
        long_stall = 1'b0;
        wait (stim_done === 1'b0 && cycles > 3000);
        @(posedge i_clk);
        long_stall = 1'b1;
        repeat (2000) @(posedge i_clk);
        long_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n_items;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_out_ready = 1'b0;
        n_errors   = 0;
        cycles     = 0;
        stim_done  = 1'b0;
        send_hold  = 1'b0;
        n_entries  = 0;
        build_len  = 0;
        build_ovf  = 1'b0;
        build_done = 1'b0;
        host_done  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, empty pattern, extremes, too long, full table
        queue_beat(mk(pwhm_pkg::OP_END, 8'h00, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_SORT, 8'hFF, 32'hFFFF_FFFF));
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'h00, 32'h7FFF_FFFF));
        queue_beat(mk(pwhm_pkg::OP_PAT, 8'h2A, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_PAT, 8'h41, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'hFF, 32'h8000_0000));
        queue_beat(mk(pwhm_pkg::OP_PAT, 8'hFF, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_PAT, 8'h3F, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'h00, 32'h8000_0000));
        queue_beat(mk(pwhm_pkg::OP_SORT, 8'h00, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_HOST, 8'h61, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_HOST, 8'hFF, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_END, 8'h00, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_END, 8'h00, 32'h0));
        queue_beat(mk(OP_SPARE5, 8'h00, 32'h0));
        queue_beat(mk(OP_SPARE6, 8'hFF, 32'hFFFF_FFFF));
        queue_beat(mk(OP_SPARE7, 8'h55, 32'h5555_5555));
        for (int k = 0; k < PATTERN_LEN + 1; k++) begin
            queue_beat(mk(pwhm_pkg::OP_PAT, 8'h5A, 32'h0));
        end
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'h00, 32'h0));
        for (int k = 0; k < PATTERN_LEN; k++) begin
            queue_beat(mk(pwhm_pkg::OP_PAT, (k == 0) ? pwhm_pkg::STAR_CH : 8'h7A, 32'h0));
        end
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'h00, 32'h0000_0001));
        for (int e = 0; e < 6; e++) begin
            add_pattern($urandom_range(0, 4), $urandom_range(0, 3));
        end
        for (int k = 0; k < PATTERN_LEN + 1; k++) begin
            queue_beat(mk(pwhm_pkg::OP_PAT, 8'h7A, 32'h0));
        end
        queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'h00, 32'h0));
        queue_beat(mk(pwhm_pkg::OP_SORT, 8'h00, 32'h0));
        for (int k = 0; k < PATTERN_LEN; k++) begin
            queue_beat(mk(pwhm_pkg::OP_HOST, 8'h5A, 32'h0));
        end
        queue_beat(mk(pwhm_pkg::OP_END, 8'h00, 32'h0));
        for (int h = 0; h < 15; h++) begin
            add_host($urandom_range(0, 5));
        end

        // wait until all results are back, then pause the sender
        send_hold = 1'b0;
        wait_drained();
        send_hold = 1'b1;
        repeat (20) @(posedge i_clk);
        send_hold = 1'b0;

        // random: the table is never cleared or rebuilt, as no reset is applied here,
        // so it stays full from the directed part and the loop mostly streams many hostnames
        n_items = 0;
        while (n_items < 600) begin
            if (n_entries < ENTRIES && $urandom_range(0, 2) == 0) begin
                add_pattern($urandom_range(0, 6), $urandom_range(0, 1) ? $urandom_range(0, 5)
                                                                       : $urandom);
                n_items += 3;
            end else begin
                if ($urandom_range(0, 5) == 0) begin
                    queue_beat(mk(pwhm_pkg::OP_SORT, 8'($urandom), $urandom));
                end
                if ($urandom_range(0, 9) == 0) begin
                    queue_beat(mk(pwhm_pkg::OP_PAT, rand_char(), $urandom));
                    queue_beat(mk(pwhm_pkg::OP_COMMIT, 8'($urandom), $urandom));
                end
                add_host($urandom_range(0, 8));
                n_items += 6;
            end
            while (pending_beats.size() > 50) begin
                @(posedge i_clk);
            end
        end
        stim_done = 1'b1;
        wait_drained();
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
